// ----- rtl/cursor_linked_list_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Linked list engine assertion macros
// Concurrent assertion wrappers on clk and rst_n, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define CLLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CLLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLLE_ASSERT_NOW(lbl, ante, cons, msg)
`define CLLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/clle_pkg.sv -----
// ----------------------------------------------------------------------------
// Linked list engine package
// Field widths, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package clle_pkg;

  localparam int CELLS_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 16;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;

  localparam logic [MODE_W-1:0] MODE_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POS   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DEL   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_IWALK,
    S_ILINK,
    S_DWALK,
    S_DFREE,
    S_DONE
  } state_t;

endpackage

// ----- rtl/cursor_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// Cursor linked list engine
// One linked list and a free chain in a fixed pool of cells, one walk step
// per cycle through registered-read link and value memories.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  request channel: in_mode (0 front, 1 back, 2 at position, 3 delete),
//         in_value, in_position. Taken when in_valid is high and in_stall low.
//   out_* result channel: out_status (0 done, 1 full, 2 not found), out_slot.
//         Taken when out_valid is high and out_stall low.
// Sequence, request accept to result valid:
//   insert front, position zero, or into an empty list: pop, done
//   insert back or at position p: pop, walk over the links, link, done
//   delete found: walk to the match, free, done
//   delete not found: walk over the list, done
//   full or empty-list miss: done
// One request is in work at a time; in_stall is high from accept until the
// result is loaded into the output register, and the next request can be
// taken in the cycle after that.
// The walk is one link memory read per cycle. A stalled result holds in the
// output register while the next request is taken; that request waits at
// its end for the register.
// Reset empties the list and chains all cells into the free chain at once
// through per-cell valid bits on the link memory; no clearing pass.
// ----------------------------------------------------------------------------
`include "cursor_linked_list_engine_assert.svh"

module cursor_linked_list_engine #(
  parameter int CELLS = clle_pkg::CELLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [clle_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [clle_pkg::VALUE_W-1:0] in_value,
  input  logic [clle_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [clle_pkg::STATUS_W-1:0]       out_status,
  output logic [clle_pkg::SLOT_W-1:0]         out_slot
);
  import clle_pkg::*;

  localparam int LW = $clog2(CELLS + 1);
  localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [LW-1:0] NIL = LW'(CELLS);

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]         mode_r, mode_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [LW-1:0]             cell_r, cell_nxt;
  logic [LW-1:0]             t_r, t_nxt;
  logic [LW-1:0]             prev_r, prev_nxt;
  logic [LW-1:0]             cnt_r, cnt_nxt;
  logic [LW-1:0]             list_head_r, list_head_nxt;
  logic [LW-1:0]             free_head_r, free_head_nxt;
  logic [STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]         res_slot_r, res_slot_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]         out_slot_r, out_slot_nxt;

  logic [LW-1:0]      links_mem [CELLS];
  logic [CELLS-1:0]   lval_r;
  logic               lwr_en;
  logic [IW-1:0]      lwr_addr;
  logic [LW-1:0]      lwr_data;
  logic [LW-1:0]      lrd_data_r;
  logic               lrd_val_r;
  logic [IW-1:0]      lrd_addr_r;

  logic [VALUE_W-1:0] vals_mem [CELLS];
  logic               vwr_en;
  logic [IW-1:0]      vwr_addr;
  logic [VALUE_W-1:0] vwr_data;
  logic [VALUE_W-1:0] vrd_data_r;

  logic [IW-1:0]      rd_addr;

  logic          accept;
  logic          out_free;
  logic [LW-1:0] eff_link;
  logic          match;
  logic          front_ins;
  logic          iwalk_more;
  logic          dwalk_end;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign eff_link  = lrd_val_r ? lrd_data_r : (LW'(lrd_addr_r) + LW'(1));
  assign match     = (vrd_data_r == val_r);
  assign front_ins = (mode_r == MODE_FRONT) || ((mode_r == MODE_POS) && (pos_r == '0)) ||
                     (list_head_r == NIL);
  assign iwalk_more = ((mode_r == MODE_BACK) || ((PW'(cnt_r) + PW'(1)) < PW'(pos_r))) &&
                      (eff_link != NIL) && (cnt_r < LW'(CELLS));
  assign dwalk_end  = (cnt_r == LW'(CELLS)) || (eff_link == NIL);

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_DEL) begin
            state_nxt = (list_head_r == NIL) ? S_DONE : S_DWALK;
          end else begin
            state_nxt = (free_head_r == NIL) ? S_DONE : S_POP;
          end
        end
      end
      S_POP:   state_nxt = front_ins ? S_DONE : S_IWALK;
      S_IWALK: state_nxt = iwalk_more ? S_IWALK : S_ILINK;
      S_ILINK: state_nxt = S_DONE;
      S_DWALK: begin
        if (match) begin
          state_nxt = S_DFREE;
        end else if (dwalk_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DFREE: state_nxt = S_DONE;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_nxt       = mode_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    cell_nxt       = cell_r;
    t_nxt          = t_r;
    prev_nxt       = prev_r;
    cnt_nxt        = cnt_r;
    list_head_nxt  = list_head_r;
    free_head_nxt  = free_head_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    lwr_en         = 1'b0;
    lwr_addr       = cell_r[IW-1:0];
    lwr_data       = list_head_r;
    vwr_en         = 1'b0;
    vwr_addr       = free_head_r[IW-1:0];
    vwr_data       = in_value;
    rd_addr        = t_r[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt = in_mode;
          val_nxt  = in_value;
          pos_nxt  = in_position;
          if (in_mode == MODE_DEL) begin
            if (list_head_r == NIL) begin
              res_status_nxt = ST_MISS;
              res_slot_nxt   = '0;
            end else begin
              t_nxt    = list_head_r;
              prev_nxt = NIL;
              cnt_nxt  = '0;
              rd_addr  = list_head_r[IW-1:0];
            end
          end else begin
            if (free_head_r == NIL) begin
              res_status_nxt = ST_FULL;
              res_slot_nxt   = '0;
            end else begin
              cell_nxt = free_head_r;
              rd_addr  = free_head_r[IW-1:0];
              vwr_en   = 1'b1;
            end
          end
        end
      end
      S_POP: begin
        free_head_nxt = eff_link;
        if (front_ins) begin
          lwr_en         = 1'b1;
          lwr_data       = list_head_r;
          list_head_nxt  = cell_r;
          res_status_nxt = ST_DONE;
          res_slot_nxt   = SLOT_W'(cell_r);
        end else begin
          t_nxt   = list_head_r;
          cnt_nxt = '0;
          rd_addr = list_head_r[IW-1:0];
        end
      end
      S_IWALK: begin
        if (iwalk_more) begin
          t_nxt   = eff_link;
          cnt_nxt = cnt_r + LW'(1);
          rd_addr = eff_link[IW-1:0];
        end else begin
          lwr_en   = 1'b1;
          lwr_data = (mode_r == MODE_BACK) ? NIL : eff_link;
        end
      end
      S_ILINK: begin
        lwr_en         = 1'b1;
        lwr_addr       = t_r[IW-1:0];
        lwr_data       = cell_r;
        res_status_nxt = ST_DONE;
        res_slot_nxt   = SLOT_W'(cell_r);
      end
      S_DWALK: begin
        if (match) begin
          if (prev_r == NIL) begin
            list_head_nxt = eff_link;
          end else begin
            lwr_en   = 1'b1;
            lwr_addr = prev_r[IW-1:0];
            lwr_data = eff_link;
          end
        end else if (dwalk_end) begin
          res_status_nxt = ST_MISS;
          res_slot_nxt   = '0;
        end else begin
          prev_nxt = t_r;
          t_nxt    = eff_link;
          cnt_nxt  = cnt_r + LW'(1);
          rd_addr  = eff_link[IW-1:0];
        end
      end
      S_DFREE: begin
        lwr_en         = 1'b1;
        lwr_addr       = t_r[IW-1:0];
        lwr_data       = free_head_r;
        free_head_nxt  = t_r;
        res_status_nxt = ST_DONE;
        res_slot_nxt   = SLOT_W'(t_r);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NIL;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
      lval_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
      if (lwr_en) begin
        lval_r[lwr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    cell_r       <= cell_nxt;
    t_r          <= t_nxt;
    prev_r       <= prev_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (lwr_en) begin
      links_mem[lwr_addr] <= lwr_data;
    end
    lrd_data_r <= links_mem[rd_addr];
    lrd_val_r  <= lval_r[rd_addr];
    lrd_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vals_mem[vwr_addr] <= vwr_data;
    end
    vrd_data_r <= vals_mem[rd_addr];
  end

  `CLLE_ASSERT_NOW(a_slot_zero_on_error, out_valid_r && (out_status_r != ST_DONE), out_slot_r == '0, "slot nonzero with error status")
  `CLLE_ASSERT_NOW(a_heads_in_range, 1'b1, (list_head_r <= NIL) && (free_head_r <= NIL), "head pointer out of range")
  `CLLE_ASSERT_NOW(a_heads_disjoint, list_head_r != NIL, list_head_r != free_head_r, "list and free chain share a head")
  `CLLE_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != S_IDLE, "request accepted but sequencer idle")

endmodule
